// ===== hw/rtl/iirdf1_pkg.sv =====
// shared types, sizes and codes for the direct form one iir filter
`default_nettype none

package iirdf1_pkg;

    // filter size and field widths
    localparam int MAX_TAPS   = 8;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int FRAC_BITS  = 24;
    localparam int KIND_W     = 2;
    localparam int CIDX_FLD_W = 4;
    localparam int TAPCFG_W   = 4;
    localparam logic [TAPCFG_W-1:0] TAP_RESET = TAPCFG_W'(2);

    // digit-serial multiplier sizing
    localparam int DIGIT_W = 8;
    localparam int NDIG    = (SAMPLE_W + DIGIT_W - 1) / DIGIT_W;
    localparam int OPND_W  = NDIG * DIGIT_W;
    localparam int DIG_W   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int MUL_W   = COEF_W + DIGIT_W + 1;
    localparam int PROD_W  = COEF_W + OPND_W;
    localparam int ACC_W   = PROD_W + $clog2(2 * MAX_TAPS + 2);

    // coefficient and history index widths
    localparam int CIDX_W = $clog2(MAX_TAPS + 1);
    localparam int HIDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_NUM    = 2'd1,
        KIND_DEN    = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // sequencer to multiply-accumulate unit controls
    typedef struct packed {
        logic clr;
        logic load;
        logic step;
        logic acc;
        logic sub;
        logic rnd;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/iirdf1_mac.sv =====
// digit-serial multiply-accumulate unit with rounding and saturation
`default_nettype none

module iirdf1_mac
    import iirdf1_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mac_ctl i_ctl,
    input  wire t_coef    i_coef,
    input  wire t_sample  i_opnd,
    output t_sample       o_y,
    output logic          o_sat
);

    localparam int Q_W = ACC_W - FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_W - 1)));
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

    t_coef                     r_coef;
    logic signed [OPND_W-1:0]  r_opnd;
    logic                      r_first;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic [DIGIT_W-1:0]        digit;
    logic signed [DIGIT_W:0]   digit_s;
    logic signed [MUL_W-1:0]   mul;
    logic signed [PROD_W-1:0]  mul_ext;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [Q_W-1:0]     q;

    // top digit first, it carries the sign
    assign digit   = r_opnd[OPND_W-1 -: DIGIT_W];
    assign digit_s = r_first ? $signed({digit[DIGIT_W-1], digit}) : $signed({1'b0, digit});
    assign mul     = $signed(r_coef) * digit_s;
    assign mul_ext = PROD_W'(mul);
    assign prod_ext = ACC_W'(r_prod);

    // operand shift line and partial product
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_coef  <= i_coef;
            r_opnd  <= OPND_W'(i_opnd);
            r_first <= 1'b1;
            r_prod  <= '0;
        end else if (i_ctl.step) begin
            r_opnd  <= r_opnd << DIGIT_W;
            r_first <= 1'b0;
            r_prod  <= (r_prod <<< DIGIT_W) + mul_ext;
        end
    end

    // accumulator, also takes the rounding half
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= i_ctl.sub ? r_acc - prod_ext : r_acc + prod_ext;
        end else if (i_ctl.rnd) begin
            r_acc <= r_acc + HALF;
        end
    end

    // floor shift and clip to sample range
    assign q = r_acc[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (q > Q_MAX) begin
            o_y   = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            o_sat = 1'b1;
        end else if (q < Q_MIN) begin
            o_y   = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            o_sat = 1'b1;
        end else begin
            o_y   = q[SAMPLE_W-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/iir_direct_form_one_filter_top.sv =====
// Direct form one IIR filter, top level: word decode, coefficient store,
// delay lines and the term sequencer around one digit-serial MAC.
// A coefficient load or history clear word leaves the sequencer idle. A sample
// word runs 2L+1 product terms (L = tap count, capped at 8) through one shared
// 32 x 8 digit multiplier; each term is a load, a digit step for each of the
// three operand digits and an accumulate, then a rounding and an output step
// follow, and the input stays stalled until the sequencer is idle again. The
// result waits in an output register and the next word is taken while it is
// stalled; the sequencer holds in its output state only when a second result
// would overwrite an untaken one.
`default_nettype none

module iir_direct_form_one_filter_top
    import iirdf1_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [TAPCFG_W-1:0]   i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [CIDX_FLD_W-1:0] i_coef_index,
    input  wire logic signed [COEF_W-1:0]   i_coef_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_filtered,
    output logic                       o_saturated
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_RND  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [TAPCFG_W-1:0]   r_tap_count;
    logic [CIDX_W-1:0]     r_taps, n_taps;
    logic [CIDX_W-1:0]     r_j, n_j;
    logic                  r_phase, n_phase;
    logic [DIG_W-1:0]      r_dig, n_dig;
    t_sample               r_x;
    t_coef                 r_num [MAX_TAPS+1];
    t_coef                 r_den [MAX_TAPS+1];
    t_sample               r_xh [MAX_TAPS];
    t_sample               r_yh [MAX_TAPS];
    logic                  r_out_valid;
    t_sample               r_filtered;
    logic                  r_saturated;

    logic                  in_acc;
    logic                  out_acc;
    logic                  out_load;
    logic [CIDX_W-1:0]     cidx;
    logic [HIDX_W-1:0]     hidx;
    logic                  idx_ok;
    logic [CIDX_W-1:0]     eff_taps;
    t_coef                 coef_sel;
    t_sample               opnd_sel;
    t_mac_ctl              mac_ctl;
    t_sample               mac_y;
    logic                  mac_sat;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_saturated;

    // index decode for coefficient words
    assign cidx   = CIDX_W'(i_coef_index);
    assign idx_ok = (32'(i_coef_index) <= MAX_TAPS);
    assign eff_taps = (32'(r_tap_count) > MAX_TAPS) ? CIDX_W'(MAX_TAPS) : CIDX_W'(r_tap_count);

    // operand select for the current term
    assign hidx     = HIDX_W'(r_j - CIDX_W'(1));
    assign coef_sel = r_phase ? r_den[r_j] : r_num[r_j];
    assign opnd_sel = (r_j == '0) ? r_x : (r_phase ? r_yh[hidx] : r_xh[hidx]);

    // tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_RESET;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    // term sequencer
    always_comb begin
        n_state = r_state;
        n_taps  = r_taps;
        n_j     = r_j;
        n_phase = r_phase;
        n_dig   = r_dig;
        mac_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_kind == KIND_SAMPLE)) begin
                    mac_ctl.clr = 1'b1;
                    n_taps  = eff_taps;
                    n_j     = '0;
                    n_phase = 1'b0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                mac_ctl.load = 1'b1;
                n_dig   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                mac_ctl.step = 1'b1;
                n_dig = r_dig + DIG_W'(1);
                if (r_dig == DIG_W'(NDIG - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                mac_ctl.acc = 1'b1;
                mac_ctl.sub = r_phase;
                n_state = S_LOAD;
                if (r_j == '0) begin
                    if (r_taps == '0) begin
                        n_state = S_RND;
                    end else begin
                        n_j = CIDX_W'(1);
                    end
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                end else if (r_j == r_taps) begin
                    n_state = S_RND;
                end else begin
                    n_j     = r_j + CIDX_W'(1);
                    n_phase = 1'b0;
                end
            end
            S_RND: begin
                mac_ctl.rnd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_taps  <= '0;
            r_j     <= '0;
            r_phase <= 1'b0;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_taps  <= n_taps;
            r_j     <= n_j;
            r_phase <= n_phase;
            r_dig   <= n_dig;
        end
    end

    // current sample
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_SAMPLE)) begin
            r_x <= i_sample;
        end
    end

    // coefficient store, denominator slot zero stays unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= MAX_TAPS; i++) begin
                r_num[i] <= '0;
                r_den[i] <= '0;
            end
        end else if (in_acc && idx_ok) begin
            if (i_kind == KIND_NUM) begin
                r_num[cidx] <= i_coef_value;
            end else if ((i_kind == KIND_DEN) && (i_coef_index != '0)) begin
                r_den[cidx] <= i_coef_value;
            end
        end
    end

    // delay lines shift over the full depth once per result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && (i_kind == KIND_CLEAR))) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else if (out_load) begin
            r_xh[0] <= r_x;
            r_yh[0] <= mac_y;
            for (int i = 1; i < MAX_TAPS; i++) begin
                r_xh[i] <= r_xh[i-1];
                r_yh[i] <= r_yh[i-1];
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_filtered  <= mac_y;
            r_saturated <= mac_sat;
        end
    end

    iirdf1_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_coef (coef_sel),
        .i_opnd (opnd_sel),
        .o_y    (mac_y),
        .o_sat  (mac_sat)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/iirdf1_checker.sv =====
// port-level checks for the iir filter top, with its bind
`default_nettype none

module iirdf1_checker
    import iirdf1_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic [KIND_W-1:0]     i_kind,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [SAMPLE_W-1:0]   o_filtered,
    input wire logic                  o_saturated
);

    localparam logic [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_filtered) && $stable(o_saturated))
        else $error("stalled result word changed");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_filtered == Y_MAX) || (o_filtered == Y_MIN))
        else $error("saturated flag without a limit value");

    // a sample word keeps the input side busy
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind == KIND_SAMPLE) |=> o_in_stall)
        else $error("input taken during sample computation");

    // other word kinds create no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind != KIND_SAMPLE) && !o_out_valid
        |=> !o_out_valid)
        else $error("result from a word that gives none");

endmodule

bind iir_direct_form_one_filter_top iirdf1_checker u_iirdf1_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_filtered  (o_filtered),
    .o_saturated (o_saturated)
);

`default_nettype wire

// ===== verif/iir_direct_form_one_filter_top_tb.sv =====
// self-checking testbench for the direct form one iir filter top level
`default_nettype none

module iir_direct_form_one_filter_top_tb
    import iirdf1_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 7;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     PHASE_WORDS   = 85;
    localparam int     NUM_PHASES    = 8;
    localparam int     HOLD_PHASE    = 2;
    localparam int     RANDOM_PHASE  = 5;
    localparam longint OUT_MAX       = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN       = -(longint'(1) <<< (SAMPLE_W - 1));

    // one stimulus word, with an optional hand-written expected output
    typedef struct packed {
        t_kind                   kind;
        t_sample                 smp;
        logic [CIDX_FLD_W-1:0]   idx;
        t_coef                   value;
        logic                    typed;
        t_sample                 want_y;
        logic                    want_sat;
    } t_stim_row;

    typedef struct packed {
        t_sample filtered;
        logic    saturated;
    } t_filter_out;

    // directed words at the reset tap count of two
    localparam t_stim_row DIRECTED_ROWS [24] = '{
        '{KIND_SAMPLE, 24'sd1234,    4'd0, 32'sd0,         1'b1, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sh7FFFFF,  4'd0, 32'sd0,         1'b1, 24'sd0,       1'b0},
        '{KIND_NUM,    24'sd0,       4'd0, 32'sh01000000,  1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sh800000,  4'd0, 32'sd0,         1'b1, 24'sh800000,  1'b0},
        '{KIND_SAMPLE, 24'sh7FFFFF,  4'd0, 32'sd0,         1'b1, 24'sh7FFFFF,  1'b0},
        '{KIND_NUM,    24'sd0,       4'd0, 32'sh7FFFFFFF,  1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sh7FFFFF,  4'd0, 32'sd0,         1'b1, 24'sh7FFFFF,  1'b1},
        '{KIND_SAMPLE, 24'sh800000,  4'd0, 32'sd0,         1'b1, 24'sh800000,  1'b1},
        '{KIND_NUM,    24'sd0,       4'd0, 32'sh80000000,  1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sd100,     4'd0, 32'sd0,         1'b1, -24'sd12800,  1'b0},
        '{KIND_SAMPLE, 24'sh7FFFFF,  4'd0, 32'sd0,         1'b1, 24'sh800000,  1'b1},
        '{KIND_NUM,    24'sd0,       4'd9, 32'sh12345678,  1'b0, 24'sd0,       1'b0},
        '{KIND_DEN,    24'sd0,       4'd0, 32'sh7FFFFFFF,  1'b0, 24'sd0,       1'b0},
        '{KIND_NUM,    24'sd0,       4'd0, 32'sh00800000,  1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sd1,       4'd0, 32'sd0,         1'b1, 24'sd1,       1'b0},
        '{KIND_SAMPLE, -24'sd1,      4'd0, 32'sd0,         1'b1, 24'sd0,       1'b0},
        '{KIND_CLEAR,  24'sd0,       4'd0, 32'sd0,         1'b0, 24'sd0,       1'b0},
        '{KIND_NUM,    24'sd0,       4'd1, 32'sh01000000,  1'b0, 24'sd0,       1'b0},
        '{KIND_DEN,    24'sd0,       4'd1, 32'sh00C00000,  1'b0, 24'sd0,       1'b0},
        '{KIND_DEN,    24'sd0,       4'd8, 32'shFF000000,  1'b0, 24'sd0,       1'b0},
        '{KIND_NUM,    24'sd0,       4'd8, 32'sh00400000,  1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sd4000000, 4'd0, 32'sd0,         1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, -24'sd3000000, 4'd0, 32'sd0,        1'b0, 24'sd0,       1'b0},
        '{KIND_SAMPLE, 24'sh800000,  4'd0, 32'sd0,         1'b0, 24'sd0,       1'b0}
    };

    localparam logic [TAPCFG_W-1:0] PHASE_TAPS [NUM_PHASES] = '{
        4'd0, 4'd8, 4'd15, 4'd1, 4'd4, 4'd0, 4'd8, 4'd2
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [TAPCFG_W-1:0]     i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [KIND_W-1:0]       i_kind;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic [CIDX_FLD_W-1:0]   i_coef_index;
    logic signed [COEF_W-1:0] i_coef_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [SAMPLE_W-1:0] o_filtered;
    logic                    o_saturated;

    // filter state as the testbench tracks it
    logic [TAPCFG_W-1:0]     tap_setting;
    t_sample                 x_delay [MAX_TAPS];
    t_sample                 y_delay [MAX_TAPS];
    t_coef                   num_coef [MAX_TAPS+1];
    t_coef                   den_coef [MAX_TAPS+1];

    t_filter_out             pending_outputs [$];
    int                      mismatch_count;
    int                      cycle_count;
    bit                      quiet;
    bit                      hold_request;

    iir_direct_form_one_filter_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_sample     (i_sample),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_filtered   (o_filtered),
        .o_saturated  (o_saturated)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("iir_direct_form_one_filter_top verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // apply one word to the tracked state; a sample yields one output word
    function automatic void filter_word(input t_kind kind, input t_sample x,
                                        input logic [CIDX_FLD_W-1:0] idx,
                                        input t_coef value, output bit gives,
                                        output t_filter_out result);
        longint acc;
        longint rounded;
        int     taps;
        gives = 1'b0;
        result = '0;
        case (kind)
            KIND_NUM: begin
                if (idx <= MAX_TAPS) num_coef[idx] = value;
            end
            KIND_DEN: begin
                // the leading denominator term is fixed at one
                if (idx >= 1 && idx <= MAX_TAPS) den_coef[idx] = value;
            end
            KIND_CLEAR: begin
                for (int j = 0; j < MAX_TAPS; j++) begin
                    x_delay[j] = '0;
                    y_delay[j] = '0;
                end
            end
            default: begin
                taps = (tap_setting > MAX_TAPS) ? MAX_TAPS : int'(tap_setting);
                acc = longint'(num_coef[0]) * longint'(x);
                for (int j = 1; j <= taps; j++) begin
                    acc += longint'(num_coef[j]) * longint'(x_delay[j-1]);
                    acc -= longint'(den_coef[j]) * longint'(y_delay[j-1]);
                end
                // round half up, then clip to the sample range
                rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                if (rounded > OUT_MAX) begin
                    result.filtered = t_sample'(OUT_MAX);
                    result.saturated = 1'b1;
                end else if (rounded < OUT_MIN) begin
                    result.filtered = t_sample'(OUT_MIN);
                    result.saturated = 1'b1;
                end else begin
                    result.filtered = t_sample'(rounded);
                end
                // delay lines always shift over their full depth
                for (int j = MAX_TAPS - 1; j > 0; j--) begin
                    x_delay[j] = x_delay[j-1];
                    y_delay[j] = y_delay[j-1];
                end
                x_delay[0] = x;
                y_delay[0] = result.filtered;
                gives = 1'b1;
            end
        endcase
    endfunction

    // offer one word, wait for the handshake, record the expected output
    task automatic send_word(input t_kind kind, input t_sample smp,
                             input logic [CIDX_FLD_W-1:0] idx, input t_coef value,
                             input bit typed, input t_sample want_y,
                             input bit want_sat);
        bit          gives;
        t_filter_out predicted;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_sample     <= smp;
        i_coef_index <= idx;
        i_coef_value <= value;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        filter_word(kind, smp, idx, value, gives, predicted);
        if (gives) begin
            if (typed) begin
                predicted.filtered = want_y;
                predicted.saturated = want_sat;
            end
            pending_outputs.push_back(predicted);
        end
    endtask

    // random word: mostly samples, with coefficient reloads and clears mixed in
    task automatic send_random_word();
        t_kind                 kind;
        t_sample               smp;
        logic [CIDX_FLD_W-1:0] idx;
        t_coef                 value;
        int                    pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) kind = KIND_SAMPLE;
        else if (pick < 78) kind = KIND_NUM;
        else if (pick < 92) kind = KIND_DEN;
        else kind = KIND_CLEAR;
        idx = ($urandom_range(0, 4) == 0) ? CIDX_FLD_W'($urandom_range(0, 15))
                                          : CIDX_FLD_W'($urandom_range(0, MAX_TAPS));
        // small coefficients keep the feedback mostly stable
        if ($urandom_range(0, 7) == 0) value = t_coef'($urandom);
        else if (kind == KIND_DEN)
            value = t_coef'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        else value = t_coef'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        case ($urandom_range(0, 7))
            0: smp = $urandom_range(0, 1) ? t_sample'(OUT_MAX) : t_sample'(OUT_MIN);
            1: smp = t_sample'(int'($urandom_range(0, 2000)) - 1000);
            default: smp = t_sample'($urandom);
        endcase
        send_word(kind, smp, idx, value, 1'b0, '0, 1'b0);
    endtask

    // tap count write, only once the filter has gone idle
    task automatic write_tap_count(input logic [TAPCFG_W-1:0] taps);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= taps;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tap_setting = taps;
    endtask

    // output receiver: random stall bursts, one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare each accepted output word with the oldest expectation
    always @(posedge i_clk) begin : check_outputs
        t_filter_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output word %0d sat %0b",
                                          o_filtered, o_saturated));
            end else begin
                want = pending_outputs.pop_front();
                if (o_filtered !== want.filtered)
                    report_mismatch($sformatf("filtered %0d, want %0d",
                                              o_filtered, want.filtered));
                if (o_saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %0b, want %0b",
                                              o_saturated, want.saturated));
            end
        end
    end

    // main sequence
    initial begin
        logic [TAPCFG_W-1:0] taps;
        mismatch_count = 0;
        quiet          = 1'b0;
        hold_request   = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_SAMPLE;
        i_sample       = '0;
        i_coef_index   = '0;
        i_coef_value   = '0;
        tap_setting    = TAP_RESET;
        for (int j = 0; j < MAX_TAPS; j++) begin
            x_delay[j] = '0;
            y_delay[j] = '0;
        end
        for (int j = 0; j <= MAX_TAPS; j++) begin
            num_coef[j] = '0;
            den_coef[j] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        foreach (DIRECTED_ROWS[i])
            send_word(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].idx,
                      DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want_y, DIRECTED_ROWS[i].want_sat);

        // random phases, each at its own tap count; no idling in the last one
        for (int p = 0; p < NUM_PHASES; p++) begin
            taps = (p == RANDOM_PHASE) ? TAPCFG_W'($urandom_range(0, 15)) : PHASE_TAPS[p];
            write_tap_count(taps);
            if (p == HOLD_PHASE) hold_request = 1'b1;
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            repeat (PHASE_WORDS) send_random_word();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_outputs.size() != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_outputs.size() != 0)
            report_mismatch($sformatf("%0d output words never arrived",
                                      pending_outputs.size()));

        if (mismatch_count == 0) begin
            $display("iir_direct_form_one_filter_top verification clean");
        end else begin
            $display("iir_direct_form_one_filter_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/iirdf1_pkg.sv
hw/rtl/iirdf1_mac.sv
hw/rtl/iir_direct_form_one_filter_top.sv
hw/rtl/iirdf1_checker.sv
verif/iir_direct_form_one_filter_top_tb.sv
